[hdl/albs_pkg.sv]
// albs_pkg: shared types, sizes and helpers for the addressable LED bit serializer.
// No dependencies; imported by every module of the block except albs_ram.
`timescale 1ns / 1ps

package albs_pkg;

  // Chain and frame sizes
  localparam int NUM_LEDS   = 16;
  localparam int DATA_BITS  = 24;
  localparam int FRAME_BITS = 32;

  // Derived widths
  localparam int COLOR_W    = 24;                                   // G,R,B word
  localparam int BIT_IDX_W  = $clog2(COLOR_W);                      // bit within word
  localparam int LED_W      = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1; // store address
  localparam int LPOS_W     = $clog2(NUM_LEDS + 1);                 // LED position
  localparam int BPOS_W     = $clog2(FRAME_BITS + 1);               // bit position
  localparam int IDX_IN_W   = 4;                                    // led_index field
  localparam int IDX_CMP_W  = (LPOS_W > IDX_IN_W) ? LPOS_W : IDX_IN_W;
  localparam int WIDTH_W    = 16;                                   // compare values
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ONE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_WIDTH = 2'd2;

  // Command codes carried on s_axis_tuser; codes 6 and 7 are ignored
  typedef enum logic [2:0] {
    OP_SET_ONE_REV = 3'd0,
    OP_SET_ALL_REV = 3'd1,
    OP_SET_ONE_DIR = 3'd2,
    OP_RESET_POS   = 3'd3,
    OP_ENABLE      = 3'd4,
    OP_TICK        = 3'd5
  } albs_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } albs_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;    // capture the incoming transaction
    logic sweep;   // write one store entry of a set-all
    logic finish;  // commit state and load the output register
  } albs_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic set_all_go;  // incoming item is an accepted set-all
    logic sweep_last;  // sweep is at the last entry
    logic out_free;    // output register can take a result
  } albs_status_t;

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] t;
    t = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
    t = ((t & 8'hCC) >> 2) | ((t & 8'h33) << 2);
    t = ((t & 8'hAA) >> 1) | ((t & 8'h55) << 1);
    return t;
  endfunction

  // Store word layout: green low, red middle, blue high
  function automatic logic [COLOR_W-1:0] pack_grb(input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b);
    return {b, r, g};
  endfunction

endpackage

[hdl/albs_ram.sv]
// albs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module albs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/albs_ctrl.sv]
// albs_ctrl: sequencing state machine for the LED serializer.
// Depends on albs_pkg; drives albs_datapath through albs_cmd_t.
`timescale 1ns / 1ps

module albs_ctrl
  import albs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  albs_status_t status,
  output albs_cmd_t    cmd
);

  albs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load   = 1'b1;
          state_next = status.set_all_go ? ST_SWEEP : ST_FINISH;
        end
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[hdl/albs_datapath.sv]
// albs_datapath: item register, colour store, positions, width registers and output register.
// Depends on albs_pkg and albs_ram; commanded by albs_ctrl.
`timescale 1ns / 1ps

module albs_datapath
  import albs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [WIDTH_W-1:0]    cfg_data,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [2:0]            s_axis_tuser,
  input  logic                  m_axis_tready,
  output logic                  m_axis_tvalid,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [0:0]            m_axis_tuser,
  output logic                  m_axis_tlast,
  input  albs_cmd_t             cmd,
  output albs_status_t          status
);

  // Configuration
  logic [WIDTH_W-1:0] one_width, zero_width, idle_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      one_width  <= '0;
      zero_width <= '0;
      idle_width <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ONE_WIDTH:  one_width  <= cfg_data;
        REG_ZERO_WIDTH: zero_width <= cfg_data;
        REG_IDLE_WIDTH: idle_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured transaction
  albs_op_t            op;
  logic [IDX_IN_W-1:0] led_index;
  logic [7:0]          red, green, blue;
  logic                enable;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= albs_op_t'(s_axis_tuser);
      led_index <= s_axis_tdata[3:0];
      red       <= s_axis_tdata[11:4];
      green     <= s_axis_tdata[19:12];
      blue      <= s_axis_tdata[27:20];
      enable    <= s_axis_tdata[28];
    end
  end

  // Positions and run flag
  logic [BPOS_W-1:0] bit_pos, bit_pos_next;
  logic [LPOS_W-1:0] led_pos, led_pos_next;
  logic              busy, busy_next;

  // Colour store: RAM plus per-entry valid bits so unwritten entries read zero
  logic [NUM_LEDS-1:0] store_valid;
  logic [LED_W-1:0]    sweep_cnt;
  logic                ram_we;
  logic [LED_W-1:0]    ram_waddr;
  logic [COLOR_W-1:0]  ram_wdata, ram_rdata;
  logic [COLOR_W-1:0]  word_rev, word_dir;
  logic [IDX_CMP_W-1:0] idx_cmp;
  logic                idx_ok;
  logic                fin_we;
  logic [COLOR_W-1:0]  fin_wdata;

  assign word_rev = pack_grb(flip8(red), flip8(green), flip8(blue));
  assign word_dir = pack_grb(red, green, blue);
  assign idx_cmp  = IDX_CMP_W'(led_index);
  assign idx_ok   = idx_cmp < IDX_CMP_W'(NUM_LEDS);

  assign ram_we    = cmd.sweep || (cmd.finish && fin_we);
  assign ram_waddr = cmd.sweep ? sweep_cnt : idx_cmp[LED_W-1:0];
  assign ram_wdata = cmd.sweep ? word_rev : fin_wdata;

  albs_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (NUM_LEDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (led_pos[LED_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      store_valid <= '0;
    end else if (ram_we) begin
      store_valid[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sweep_cnt + 1'b1;
    end
  end

  // Current bit of the LED being sent; positions past the colour word read zero
  logic data_bit;
  always_comb begin
    data_bit = 1'b0;
    if (store_valid[led_pos[LED_W-1:0]] && (bit_pos < BPOS_W'(COLOR_W))) begin
      data_bit = ram_rdata[bit_pos[BIT_IDX_W-1:0]];
    end
  end

  // Result of the captured transaction
  logic               res_pulse, res_done, res_rej;
  logic [WIDTH_W-1:0] res_width;
  logic [BPOS_W-1:0]  bit_pos_inc;
  logic [LPOS_W-1:0]  led_pos_adv;

  always_comb begin
    bit_pos_next = bit_pos;
    led_pos_next = led_pos;
    busy_next    = busy;
    res_pulse    = 1'b0;
    res_width    = '0;
    res_done     = 1'b0;
    res_rej      = 1'b0;
    fin_we       = 1'b0;
    fin_wdata    = word_dir;
    bit_pos_inc  = bit_pos + 1'b1;
    led_pos_adv  = led_pos;
    unique case (op)
      OP_SET_ONE_REV, OP_SET_ALL_REV: begin
        if (busy) begin
          res_rej = 1'b1;
        end else begin
          fin_we       = (op == OP_SET_ONE_REV) && idx_ok;
          fin_wdata    = word_rev;
          bit_pos_next = '0;
          led_pos_next = '0;
          busy_next    = enable;
        end
      end
      OP_SET_ONE_DIR: begin
        fin_we = idx_ok;
      end
      OP_RESET_POS: begin
        bit_pos_next = '0;
        led_pos_next = '0;
      end
      OP_ENABLE: begin
        busy_next = enable;
      end
      OP_TICK: begin
        if (busy) begin
          res_pulse = 1'b1;
          if (led_pos >= LPOS_W'(NUM_LEDS)) begin
            // running past the chain: one dwell period, then stop
            res_width = idle_width;
            res_done  = 1'b1;
            busy_next = 1'b0;
          end else begin
            if (bit_pos < BPOS_W'(DATA_BITS)) begin
              res_width = data_bit ? one_width : zero_width;
            end else begin
              res_width = idle_width;
            end
            if (bit_pos_inc >= BPOS_W'(FRAME_BITS)) begin
              bit_pos_next = '0;
              led_pos_adv  = led_pos + 1'b1;
            end else begin
              bit_pos_next = bit_pos_inc;
            end
            led_pos_next = led_pos_adv;
            if (led_pos_adv >= LPOS_W'(NUM_LEDS)) begin
              res_done  = 1'b1;
              busy_next = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_pos <= '0;
      led_pos <= '0;
      busy    <= 1'b0;
    end else if (cmd.finish) begin
      bit_pos <= bit_pos_next;
      led_pos <= led_pos_next;
      busy    <= busy_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_axis_tdata <= {{(OUT_DATA_W - WIDTH_W - 2){1'b0}}, busy_next, res_rej, res_width};
      m_axis_tuser <= res_pulse;
      m_axis_tlast <= res_done;
    end
  end

  assign status.set_all_go = (albs_op_t'(s_axis_tuser) == OP_SET_ALL_REV) && !busy;
  assign status.sweep_last = sweep_cnt == LED_W'(NUM_LEDS - 1);
  assign status.out_free   = !m_axis_tvalid || m_axis_tready;

endmodule

[hdl/addressable_led_bit_serializer_top.sv]
// addressable_led_bit_serializer_top: top level of the LED colour store and pulse serializer.
// Depends on albs_pkg, albs_ctrl and albs_datapath (which holds albs_ram).
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+------------------------------------
//  s_axis   | in        | tvalid/tready                | tuser: command; tdata: index, RGB, en
//  m_axis   | out       | tvalid/tready                | tuser: pulse_valid; tlast: frame_done;
//           |           |                              | tdata: width, rejected, running
//  cfg      | in        | cfg_we, no wait              | cfg_index, cfg_data (16 bit widths)
//
// Sequence: a transaction is captured in the item register, and the finishing step then
// registers its result; set-all first writes the store one entry a cycle through the
// single RAM write port. No new transaction is taken until the finishing step is done.
// Stalls: a new transaction is taken while the previous result waits in the output
// register; the finishing step waits for that register to drain.
// Reset: synchronous; per-entry valid bits clear the store at once, no clearing pass.
`timescale 1ns / 1ps

module addressable_led_bit_serializer_top
  import albs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [WIDTH_W-1:0]    cfg_data,
  // command stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // led_index[3:0], red, green, blue, enable, pad
  input  logic [2:0]            s_axis_tuser,   // command
  // pulse stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // pulse_width[15:0], rejected, running, pad
  output logic [0:0]            m_axis_tuser,   // pulse_valid
  output logic                  m_axis_tlast    // frame_done
);

  albs_cmd_t    cmd;
  albs_status_t status;

  // Controller: idle / sweep / finish sequencing
  albs_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  // Datapath: store, positions, widths and the output register
  albs_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

[hdl/albs_checker.sv]
// albs_checker: port-level assertions for the LED serializer, bound to the top level.
// Depends on albs_pkg.
`timescale 1ns / 1ps

module albs_checker
  import albs_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]            m_axis_tuser,
  input logic                  m_axis_tlast
);

  // frame end only on a real pulse, and it leaves the transmitter stopped
  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0] && !m_axis_tdata[17])
    else $error("frame_done without pulse or with running set");

  // no pulse means a zero width
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[15:0] == '0)
    else $error("pulse_width non-zero without pulse");

  // a refused write is never a pulse, and refusal means still running
  a_reject: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[16] |-> !m_axis_tuser[0] && m_axis_tdata[17])
    else $error("rejected result inconsistent");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

endmodule

bind addressable_led_bit_serializer_top albs_checker u_albs_checker (.*);

[tb/addressable_led_bit_serializer_top_tb.sv]
// Self-checking bench for addressable_led_bit_serializer_top: colour writes, run control
// and per-tick pulse widths are predicted in a scoreboard class and compared per field.
// Depends on albs_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module addressable_led_bit_serializer_top_tb;
  import albs_pkg::*;

  // Command codes the block ignores; not part of the package enum
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  localparam int SETTLE_CYCLES  = NUM_LEDS + 4;  // set-all walks the store, plus margin
  localparam int HOLD_CYCLES    = 300;           // long receiver back-pressure
  localparam int HOLD_AT        = 400;           // results seen before the hold starts
  localparam int WATCHDOG_LIMIT = 2000;          // cycles with no transaction at all
  localparam int FRAME_TICKS    = NUM_LEDS * FRAME_BITS;

  // One command transaction, unpacked
  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       en;
  } led_cmd_t;

  // One pulse transaction, unpacked
  typedef struct packed {
    logic        pulse_valid;
    logic [15:0] width;
    logic        frame_done;
    logic        rejected;
    logic        running;
  } pulse_t;

  // Commands that leave a running frame alone (set-rev ones are refused while busy)
  localparam logic [2:0] QUIET_OPS [5] = '{OP_SET_ONE_REV, OP_SET_ALL_REV, OP_SET_ONE_DIR,
                                           OP_UNUSED_6, OP_UNUSED_7};

  // ---------------------------------------------------------------------------
  // Scoreboard: shadow colour store, positions and run flag; queue of pulses due
  // ---------------------------------------------------------------------------
  class pulse_scoreboard;
    logic [COLOR_W-1:0] colours [NUM_LEDS];
    int unsigned        bit_pos;
    int unsigned        led_pos;
    logic               busy;
    logic [15:0]        one_w, zero_w, idle_w;
    pulse_t             pulses_due [$];
    int unsigned        checked, fails, pulses, frames, refusals, accepted;

    function new();
      foreach (colours[i]) colours[i] = '0;
      bit_pos = 0;
      led_pos = 0;
      busy    = 1'b0;
      one_w   = '0;
      zero_w  = '0;
      idle_w  = '0;
    endfunction

    function void set_widths(logic [15:0] one_v, logic [15:0] zero_v, logic [15:0] idle_v);
      one_w  = one_v;
      zero_w = zero_v;
      idle_w = idle_v;
    endfunction

    function int unsigned pending();
      return pulses_due.size();
    endfunction

    // mirror a byte end for end: the wire sends the stored word from bit 0 up, so a mirrored colour goes MSB first
    function logic [7:0] mirror8(logic [7:0] v);
      logic [7:0] m;
      for (int k = 0; k < 8; k++) m[k] = v[7-k];
      return m;
    endfunction

    // Accepted command: advance the shadow state and queue the pulse it causes
    function void note_cmd(led_cmd_t c);
      pulse_t             p;
      logic [COLOR_W-1:0] word;
      p    = '0;
      word = {mirror8(c.blue), mirror8(c.red), mirror8(c.green)};
      accepted++;
      case (c.cmd)
        OP_SET_ONE_REV, OP_SET_ALL_REV: begin
          if (busy) begin
            p.rejected = 1'b1;
          end else begin
            if (c.cmd == OP_SET_ONE_REV) colours[c.idx] = word;
            else foreach (colours[i]) colours[i] = word;
            bit_pos = 0;
            led_pos = 0;
            busy    = c.en;
          end
        end
        OP_SET_ONE_DIR: colours[c.idx] = {c.blue, c.red, c.green};
        OP_RESET_POS: begin
          bit_pos = 0;
          led_pos = 0;
        end
        OP_ENABLE: busy = c.en;
        OP_TICK: begin
          if (busy) begin
            p.pulse_valid = 1'b1;
            if (led_pos >= NUM_LEDS) begin
              // re-enabled past the chain: one dwell pulse and stop, positions kept
              p.width      = idle_w;
              p.frame_done = 1'b1;
              busy         = 1'b0;
            end else begin
              if (bit_pos < DATA_BITS) p.width = colours[led_pos][bit_pos] ? one_w : zero_w;
              else p.width = idle_w;
              bit_pos++;
              if (bit_pos >= FRAME_BITS) begin
                bit_pos = 0;
                led_pos++;
              end
              if (led_pos >= NUM_LEDS) begin
                p.frame_done = 1'b1;
                busy         = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
      p.running = busy;
      pulses  += 32'(p.pulse_valid);
      frames  += 32'(p.frame_done);
      refusals += 32'(p.rejected);
      pulses_due.push_back(p);
    endfunction

    function void match_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        fails++;
      end
    endfunction

    function void check_pulse(pulse_t got);
      pulse_t want;
      if (pulses_due.size() == 0) begin
        $error("pulse transaction with nothing expected: %p", got);
        fails++;
        return;
      end
      want = pulses_due.pop_front();
      checked++;
      match_field("pulse_valid", 16'(want.pulse_valid), 16'(got.pulse_valid));
      match_field("pulse_width", want.width, got.width);
      match_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
      match_field("rejected", 16'(want.rejected), 16'(got.rejected));
      match_field("running", 16'(want.running), 16'(got.running));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT and clock
  // ---------------------------------------------------------------------------
  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [WIDTH_W-1:0]    cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [2:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  pulse_scoreboard sb;
  int unsigned     items_sent;
  int unsigned     quiet_cycles;
  int unsigned     settings_used;

  addressable_led_bit_serializer_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Monitors: sample both handshakes on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    led_cmd_t c;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      c.cmd   = s_axis_tuser;
      c.idx   = s_axis_tdata[3:0];
      c.red   = s_axis_tdata[11:4];
      c.green = s_axis_tdata[19:12];
      c.blue  = s_axis_tdata[27:20];
      c.en    = s_axis_tdata[28];
      sb.note_cmd(c);
    end
  end

  always @(posedge clk) begin
    pulse_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.pulse_valid = m_axis_tuser[0];
      got.width       = m_axis_tdata[15:0];
      got.rejected    = m_axis_tdata[16];
      got.running     = m_axis_tdata[17];
      got.frame_done  = m_axis_tlast;
      sb.check_pulse(got);
    end
  end

  // Watchdog: any cycle without a transaction on either side counts towards the limit
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $error("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pulse receiver: random stalls, one calm window, one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    bit hold_pending;
    bit rx_calm;
    hold_pending  = 1'b1;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending && sb != null && sb.checked >= HOLD_AT) begin
        // sender keeps offering, so the block fills up and drops s_axis_tready
        hold_pending = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rx_calm = (sb != null) && (sb.checked >= 1300) && (sb.checked < 1550);
      m_axis_tready <= rx_calm || ($urandom_range(99) >= 16);
    end
  end

  // ---------------------------------------------------------------------------
  // Command driver tasks
  // ---------------------------------------------------------------------------
  function automatic led_cmd_t make_cmd(logic [2:0] op, logic [3:0] idx, logic [7:0] r,
                                        logic [7:0] g, logic [7:0] b, logic en);
    led_cmd_t c;
    c.cmd   = op;
    c.idx   = idx;
    c.red   = r;
    c.green = g;
    c.blue  = b;
    c.en    = en;
    return c;
  endfunction

  // every field random, command over all eight codes
  function automatic led_cmd_t random_cmd();
    logic [31:0] r;
    r = $urandom();
    return make_cmd(r[31:29], r[3:0], r[11:4], r[19:12], r[27:20], r[28]);
  endfunction

  // Offer one transaction, with random idle cycles ahead of it, and wait until taken
  task automatic send(input led_cmd_t c);
    bit tx_calm;
    @(negedge clk);
    tx_calm = (items_sent >= 900) && (items_sent < 1150);
    while (!tx_calm && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.cmd;
    s_axis_tdata  <= {3'b000, c.en, c.blue, c.green, c.red, c.idx};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // Drop valid and wait for every pulse due, then for the set-all walk to be over
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_widths(input logic [15:0] one_v, input logic [15:0] zero_v,
                                input logic [15:0] idle_v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ONE_WIDTH;
    cfg_data  <= one_v;
    @(negedge clk);
    cfg_index <= REG_ZERO_WIDTH;
    cfg_data  <= zero_v;
    @(negedge clk);
    cfg_index <= REG_IDLE_WIDTH;
    cfg_data  <= idle_v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_widths(one_v, zero_v, idle_v);
    settings_used++;
  endtask

  // A whole frame to the end, with refused writes, direct writes and ignored codes
  // mixed in, then ticks while stopped and one tick past the chain.
  task automatic run_full_frame();
    led_cmd_t    c;
    int unsigned ticks;
    ticks = 0;
    c = random_cmd();
    c.cmd = OP_ENABLE;
    c.en  = 1'b0;
    send(c);
    c = random_cmd();
    c.cmd = ($urandom_range(1) == 0) ? OP_SET_ALL_REV : OP_SET_ONE_REV;
    c.en  = 1'b1;
    send(c);
    while (ticks < FRAME_TICKS) begin
      c = random_cmd();
      if ($urandom_range(99) < 90) begin
        c.cmd = OP_TICK;
        ticks++;
      end else begin
        c.cmd = QUIET_OPS[$urandom_range(4)];
      end
      send(c);
    end
    repeat (2) send(make_cmd(OP_TICK, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0));
    send(make_cmd(OP_ENABLE, 4'h0, 8'h00, 8'h00, 8'h00, 1'b1));
    repeat (2) send(make_cmd(OP_TICK, 4'hF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
  endtask

  // Short runs: a start command then a handful of ticks, with lone random items between
  task automatic run_bursts(input int unsigned quota);
    led_cmd_t    c;
    int unsigned stop_at;
    int unsigned n;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      c = random_cmd();
      if ($urandom_range(99) >= 15) begin
        case ($urandom_range(3))
          0: c.cmd = OP_SET_ALL_REV;
          1: begin
            c.cmd = OP_SET_ONE_REV;
            c.en  = 1'b1;
          end
          2: begin
            c.cmd = OP_ENABLE;
            c.en  = 1'b1;
          end
          default: c.cmd = OP_RESET_POS;
        endcase
        send(c);
        n = $urandom_range(40, 1);
        repeat (n) begin
          c = random_cmd();
          if ($urandom_range(99) < 85) c.cmd = OP_TICK;
          send(c);
        end
      end else begin
        send(c);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    sb            = new();
    items_sent    = 0;
    settings_used = 0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: widths at the extremes, each command, each corner of the run logic
    program_widths(16'hFFFF, 16'h0000, 16'h8001);
    send(make_cmd(OP_TICK, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0));         // tick while stopped
    send(make_cmd(OP_UNUSED_6, 4'hF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send(make_cmd(OP_UNUSED_7, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0));
    send(make_cmd(OP_RESET_POS, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0));
    send(make_cmd(OP_SET_ALL_REV, 4'h0, 8'h00, 8'hFF, 8'h80, 1'b0));
    send(make_cmd(OP_SET_ONE_DIR, 4'hF, 8'hFF, 8'h00, 8'hFF, 1'b1));
    send(make_cmd(OP_SET_ONE_REV, 4'h0, 8'h01, 8'h80, 8'hC3, 1'b1));   // start running
    repeat (3) send(make_cmd(OP_TICK, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0));
    send(make_cmd(OP_SET_ONE_REV, 4'h5, 8'h12, 8'h34, 8'h56, 1'b1));   // refused: running
    send(make_cmd(OP_SET_ALL_REV, 4'h0, 8'hFF, 8'hFF, 8'hFF, 1'b0));   // refused: running
    send(make_cmd(OP_SET_ONE_DIR, 4'h0, 8'h5A, 8'hA5, 8'hFF, 1'b0));   // taken while running
    send(make_cmd(OP_TICK, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0));
    send(make_cmd(OP_RESET_POS, 4'hF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send(make_cmd(OP_TICK, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0));
    send(make_cmd(OP_ENABLE, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0));
    send(make_cmd(OP_TICK, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0));
    send(make_cmd(OP_ENABLE, 4'h0, 8'h00, 8'h00, 8'h00, 1'b1));
    send(make_cmd(OP_TICK, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0));
    send(make_cmd(OP_ENABLE, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0));
    settle();

    // Random part, one width setting per phase
    program_widths(16'h0000, 16'hFFFF, 16'h0000);
    run_full_frame();
    run_bursts(20);
    settle();

    program_widths(16'($urandom()), 16'($urandom()), 16'($urandom()));
    run_bursts(340);
    settle();

    program_widths(16'($urandom()), 16'($urandom()), 16'hFFFF);
    run_full_frame();
    run_bursts(20);
    settle();

    program_widths(16'h7FFE, 16'h8000, 16'($urandom()));
    run_bursts(340);
    settle();

    if (sb.pending() != 0) begin
      $error("%0d pulse transactions never arrived", sb.pending());
      sb.fails++;
    end
    $display("Ran %0d commands under %0d width settings; checked %0d pulse transactions.",
             sb.accepted, settings_used, sb.checked);
    $display("Seen %0d width pulses, %0d frame ends and %0d refused colour writes.",
             sb.pulses, sb.frames, sb.refusals);
    if (sb.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/albs_pkg.sv
hdl/albs_ram.sv
hdl/albs_ctrl.sv
hdl/albs_datapath.sv
hdl/addressable_led_bit_serializer_top.sv
hdl/albs_checker.sv
tb/addressable_led_bit_serializer_top_tb.sv
